[hw/rtl/smsq_pkg.sv]
// smsq_pkg: shared types and constants for the stepper move sequencer.
// No dependencies; imported by every module of the block.
package smsq_pkg;

  localparam int ElapsedW   = 26;
  localparam int RemainW    = 15;
  localparam int StepsW     = 16;
  localparam int CoilW      = 4;
  localparam int CfgAddrW   = 2;
  localparam int CfgDataW   = 32;

  localparam logic [ElapsedW-1:0] ElapsedMax        = {ElapsedW{1'b1}};
  localparam logic [RemainW-1:0]  RemainMax         = {RemainW{1'b1}};
  localparam logic [ElapsedW-1:0] StepIntervalReset = ElapsedW'(3000);
  // full-step drive sequence, read as a sliding four-bit window
  localparam logic [7:0]          CoilPattern       = 8'hCC;
  // slow-down zone near the end of a move
  localparam logic [RemainW-1:0]  SlowZoneSteps     = RemainW'(10);
  localparam int                  SlowStepUs        = 100;

  // register byte address
  localparam logic [CfgAddrW-1:0] REG_STEP_INTERVAL = 2'd0;

  // request kinds carried on in_tuser
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_MOVE = 1'b1;

  typedef struct packed {
    logic             rejected;
    logic             move_done;
    logic             busy_res;
    logic [CoilW-1:0] coils;
  } res_t;

endpackage

[hw/rtl/stepper_move_sequencer_top.sv]
// Stepper move sequencer: one tick or move transaction in, one result out
// per transaction. A transaction is taken when in_tvalid and in_tready are
// both high; its result appears in the next cycle from the result register.
// in_tready is high while the result register is empty or is being drained
// in the same cycle, so the sustained rate is one transaction per clock
// while out_tready stays high. Ticks (in_tuser = 0) count microseconds and
// issue steps; moves (in_tuser = 1) load a signed step count from in_tdata.
// Depends on smsq_pkg, smsq_cfg, smsq_core.
module stepper_move_sequencer_top import smsq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata: [15:0] move_steps
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,
  // in_tuser: [0] req_type
  input  logic                in_tuser,
  // out_tdata: [3:0] coils, [4] busy_res, [5] move_done, [6] rejected, [7] zero
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  logic [ElapsedW-1:0] step_interval;
  res_t                res;
  res_t                out_r;
  logic                out_valid_r, out_valid_nxt;
  logic                in_fire;
  logic                done_seen_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  smsq_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .step_interval (step_interval)
  );

  smsq_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .req_type      (in_tuser),
    .move_steps    (in_tdata),
    .step_interval (step_interval),
    .res           (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_seen_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        done_seen_r <= res.move_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.rejected, out_r.move_done, out_r.busy_res, out_r.coils};

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction did not load the result register");

  a_busy_move_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == REQ_MOVE && out_valid_r && out_r.busy_res && out_tready)
    |=> out_r.rejected)
    else $error("move while busy was not rejected");

  a_coils_off_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && done_seen_r) |-> (res.coils == '0))
    else $error("coils not switched off after final step");

endmodule

[hw/rtl/smsq_cfg.sv]
// smsq_cfg: APB-style register file holding step_interval.
// Depends on smsq_pkg.
module smsq_cfg import smsq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic [ElapsedW-1:0] step_interval
);

  logic [ElapsedW-1:0] step_interval_r;
  logic [ElapsedW-1:0] step_interval_nxt;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    step_interval_nxt = step_interval_r;
    if (wr_en && (paddr == REG_STEP_INTERVAL)) begin
      step_interval_nxt = pwdata[ElapsedW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_interval_r <= StepIntervalReset;
    end else begin
      step_interval_r <= step_interval_nxt;
    end
  end

  always_comb begin
    unique case (paddr)
      REG_STEP_INTERVAL: prdata = CfgDataW'(step_interval_r);
      default:           prdata = '0;
    endcase
  end

  assign step_interval = step_interval_r;

endmodule

[hw/rtl/smsq_core.sv]
// smsq_core: move state and step timing; computes one result per transaction.
// Depends on smsq_pkg. State advances only on an accepted input transaction.
module smsq_core import smsq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                req_type,
  input  logic [StepsW-1:0]   move_steps,
  input  logic [ElapsedW-1:0] step_interval,
  output res_t                res
);

  logic [RemainW-1:0]  rem_r, rem_nxt;
  logic                rev_r, rev_nxt;
  logic [ElapsedW-1:0] elapsed_r, elapsed_nxt;
  logic                first_r, first_nxt;
  logic [CoilW-1:0]    coil_r, coil_nxt;
  logic                clear_r, clear_nxt;

  logic [StepsW-1:0]   abs_steps;
  logic [RemainW-1:0]  mag;
  logic [ElapsedW-1:0] elapsed_inc;
  logic [ElapsedW:0]   thr_sum;
  logic [ElapsedW-1:0] thr;
  logic [RemainW-1:0]  rem_dec;
  logic [1:0]          phase;
  logic [CoilW-1:0]    step_coils;
  logic                busy;
  logic                issue;
  logic                done;
  logic                rej;

  assign busy      = (rem_r != '0);
  assign abs_steps = move_steps[StepsW-1] ? StepsW'(-move_steps) : move_steps;
  // most negative count saturates to the largest step count
  assign mag       = abs_steps[StepsW-1] ? RemainMax : abs_steps[RemainW-1:0];

  assign elapsed_inc = (elapsed_r == ElapsedMax) ? elapsed_r : elapsed_r + 1'b1;
  assign thr_sum = {1'b0, step_interval} +
                   ((rem_r < SlowZoneSteps) ?
                    (ElapsedW+1)'(rem_r[3:0]) * (ElapsedW+1)'(SlowStepUs) :
                    (ElapsedW+1)'(0));
  assign thr = thr_sum[ElapsedW] ? ElapsedMax : thr_sum[ElapsedW-1:0];

  assign rem_dec    = rem_r - 1'b1;
  assign phase      = rev_r ? rem_dec[1:0] : 2'(2'd0 - rem_dec[1:0]);
  assign step_coils = CoilW'(CoilPattern >> phase);

  always_comb begin
    rem_nxt     = rem_r;
    rev_nxt     = rev_r;
    elapsed_nxt = elapsed_r;
    first_nxt   = first_r;
    coil_nxt    = clear_r ? '0 : coil_r;
    clear_nxt   = 1'b0;
    issue       = 1'b0;
    done        = 1'b0;
    rej         = 1'b0;

    if (req_type == REQ_MOVE) begin
      if (busy) begin
        rej = 1'b1;
      end else if (move_steps != '0) begin
        rem_nxt     = mag;
        rev_nxt     = move_steps[StepsW-1];
        first_nxt   = 1'b1;
        elapsed_nxt = '0;
      end
    end else begin
      if (busy && first_r) begin
        first_nxt = 1'b0;
        issue     = 1'b1;
      end else begin
        elapsed_nxt = elapsed_inc;
        issue       = busy && (elapsed_inc >= thr);
      end
    end

    if (issue) begin
      rem_nxt     = rem_dec;
      coil_nxt    = step_coils;
      elapsed_nxt = '0;
      if (rem_dec == '0) begin
        first_nxt = 1'b0;
        clear_nxt = 1'b1;
        done      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      rev_r     <= 1'b0;
      elapsed_r <= '0;
      first_r   <= 1'b0;
      coil_r    <= '0;
      clear_r   <= 1'b0;
    end else if (in_fire) begin
      rem_r     <= rem_nxt;
      rev_r     <= rev_nxt;
      elapsed_r <= elapsed_nxt;
      first_r   <= first_nxt;
      coil_r    <= coil_nxt;
      clear_r   <= clear_nxt;
    end
  end

  always_comb begin
    res.coils     = coil_nxt;
    res.busy_res  = (rem_nxt != '0);
    res.move_done = done;
    res.rejected  = rej;
  end

endmodule
